>>> rtl/usip_pkg.sv
// Package for the unsigned integer string parser: item types, phase codes, character codes.
package usip_pkg;

	// One character item of the string
	typedef struct packed {
		logic [7:0] char_code;
		logic [4:0] number_base;
	} usip_char_t;

	// One result item, sent on the terminating NUL
	typedef struct packed {
		logic [63:0] parsed_value;
		logic        parse_status;
	} usip_result_t;

	// Parse phases
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_DIGITS = 3'd3;
	localparam logic [2:0] PH_NEWL   = 3'd4;
	localparam logic [2:0] PH_DRAIN  = 3'd5;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_F  = 8'd70;
	localparam logic [7:0] CH_UP_X  = 8'd88;
	localparam logic [7:0] CH_LO_A  = 8'd97;
	localparam logic [7:0] CH_LO_F  = 8'd102;
	localparam logic [7:0] CH_LO_X  = 8'd120;

	// Bases
	localparam logic [4:0] BASE_INFER = 5'd0;
	localparam logic [4:0] BASE_OCT   = 5'd8;
	localparam logic [4:0] BASE_DEC   = 5'd10;
	localparam logic [4:0] BASE_HEX   = 5'd16;

	// Status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

>>> rtl/unsigned_integer_string_parser_top.sv
// Top level of the unsigned integer string parser: input register, parse step, result register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------
//  char     | char_valid / char_stall      | char_item   (char_code, number_base)
//  result   | result_valid / result_stall  | result_item (parsed_value, status)
//
// One character item is taken every cycle while char_stall is low; the rate is set by the single parse step
// (a 64-bit by 5-bit multiply-add) between the input register and the state registers.
// A result is registered from its NUL item in the input register, one result per NUL item.
// Reset returns the parser to the start of a string and empties both registers.
// char_stall rises only when a NUL item waits in the input register while a result
// is still held by result_stall; other characters move on regardless.
module unsigned_integer_string_parser_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  usip_pkg::usip_char_t   char_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output usip_pkg::usip_result_t result_item
);

	// Input register
	logic                 valid_s1;
	usip_pkg::usip_char_t item_s1;

	// Parse state
	logic [63:0] acc_q;
	logic [2:0]  phase_q;
	logic [4:0]  base_q;
	logic        saw_digit_q;
	logic        err_q;

	// Step outputs
	logic [63:0] acc_d;
	logic [2:0]  phase_d;
	logic [4:0]  base_d;
	logic        saw_digit_d;
	logic        err_d;
	logic        emit;
	logic [63:0] emit_value;
	logic        emit_status;

	logic        is_nul_s1;
	logic        blocked;
	logic        fire;

	logic [7:0]  c;
	logic        is_dig;
	logic [4:0]  dig;
	logic        do_digit;
	logic [63:0] prod;

	assign c         = item_s1.char_code;
	assign is_nul_s1 = (c == usip_pkg::CH_NUL);
	assign blocked   = valid_s1 && is_nul_s1 && result_valid && result_stall;
	assign fire      = valid_s1 && !blocked;
	assign char_stall = blocked;

	// Decode a hex-style digit
	always_comb begin
		is_dig = 1'b1;
		dig    = 5'd0;
		if (c >= usip_pkg::CH_ZERO && c <= usip_pkg::CH_NINE) begin
			dig = 5'(c - usip_pkg::CH_ZERO);
		end else if (c >= usip_pkg::CH_LO_A && c <= usip_pkg::CH_LO_F) begin
			dig = 5'(c - usip_pkg::CH_LO_A + 8'd10);
		end else if (c >= usip_pkg::CH_UP_A && c <= usip_pkg::CH_UP_F) begin
			dig = 5'(c - usip_pkg::CH_UP_A + 8'd10);
		end else begin
			is_dig = 1'b0;
		end
	end

	// Parse step for the item in the input register
	always_comb begin
		acc_d       = acc_q;
		phase_d     = phase_q;
		base_d      = base_q;
		saw_digit_d = saw_digit_q;
		err_d       = err_q;
		emit        = 1'b0;
		do_digit    = 1'b0;
		prod        = '0;

		// Sample the base on the first item of a string
		if (phase_d == usip_pkg::PH_START) begin
			base_d  = item_s1.number_base;
			phase_d = usip_pkg::PH_SPACE;
		end

		case (phase_d)
			usip_pkg::PH_SPACE: begin
				if (is_nul_s1) begin
					emit = 1'b1;
				end else if (c == usip_pkg::CH_SPACE ||
				             (c >= usip_pkg::CH_TAB && c <= usip_pkg::CH_CR)) begin
					// skip leading whitespace
				end else if (c == usip_pkg::CH_ZERO &&
				             (base_d == usip_pkg::BASE_INFER ||
				              base_d == usip_pkg::BASE_HEX)) begin
					phase_d = usip_pkg::PH_ZERO;
				end else begin
					if (base_d == usip_pkg::BASE_INFER) begin
						base_d = usip_pkg::BASE_DEC;
					end
					do_digit = 1'b1;
				end
			end
			usip_pkg::PH_ZERO: begin
				if (c == usip_pkg::CH_LO_X || c == usip_pkg::CH_UP_X) begin
					base_d  = usip_pkg::BASE_HEX;
					phase_d = usip_pkg::PH_DIGITS;
				end else if (base_d == usip_pkg::BASE_INFER) begin
					if (is_nul_s1) begin
						base_d      = usip_pkg::BASE_DEC;
						saw_digit_d = 1'b1;
						acc_d       = '0;
						emit        = 1'b1;
					end else begin
						base_d   = usip_pkg::BASE_OCT;
						do_digit = 1'b1;
					end
				end else begin
					// hex with no prefix: the zero counts as a digit
					acc_d       = '0;
					saw_digit_d = 1'b1;
					phase_d     = usip_pkg::PH_DIGITS;
					if (is_nul_s1) begin
						emit = 1'b1;
					end else begin
						do_digit = 1'b1;
					end
				end
			end
			usip_pkg::PH_DIGITS: begin
				if (is_nul_s1) begin
					emit = 1'b1;
				end else begin
					do_digit = 1'b1;
				end
			end
			usip_pkg::PH_NEWL: begin
				if (is_nul_s1) begin
					emit = 1'b1;
				end else begin
					err_d   = 1'b1;
					phase_d = usip_pkg::PH_DRAIN;
				end
			end
			default: begin
				err_d = 1'b1;
				if (is_nul_s1) begin
					emit = 1'b1;
				end else begin
					phase_d = usip_pkg::PH_DRAIN;
				end
			end
		endcase

		// Accumulate one digit, or mark a trailing newline or an error
		if (do_digit) begin
			if (is_dig) begin
				if (dig >= base_d) begin
					err_d   = 1'b1;
					phase_d = usip_pkg::PH_DRAIN;
				end else begin
					prod        = acc_d * {59'd0, base_d};
					acc_d       = prod + {59'd0, dig};
					saw_digit_d = 1'b1;
					phase_d     = usip_pkg::PH_DIGITS;
				end
			end else if (c == usip_pkg::CH_LF) begin
				phase_d = usip_pkg::PH_NEWL;
			end else begin
				err_d   = 1'b1;
				phase_d = usip_pkg::PH_DRAIN;
			end
		end

		// Build the result and return to the start of a string
		emit_status = (saw_digit_d && !err_d) ? usip_pkg::STATUS_OK : usip_pkg::STATUS_ERR;
		emit_value  = (emit_status == usip_pkg::STATUS_OK) ? acc_d : 64'd0;
		if (emit) begin
			acc_d       = '0;
			phase_d     = usip_pkg::PH_START;
			base_d      = '0;
			saw_digit_d = 1'b0;
			err_d       = 1'b0;
		end
	end

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= char_item;
		end
	end

	// Advance the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			phase_q     <= usip_pkg::PH_START;
			base_q      <= '0;
			saw_digit_q <= 1'b0;
			err_q       <= 1'b0;
		end else if (fire) begin
			acc_q       <= acc_d;
			phase_q     <= phase_d;
			base_q      <= base_d;
			saw_digit_q <= saw_digit_d;
			err_q       <= err_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fire && emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			result_item.parsed_value <= emit_value;
			result_item.parse_status <= emit_status;
		end
	end

	// An error result carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.parse_status |-> result_item.parsed_value == 64'd0)
		else $error("error result with nonzero value");

	// A sent result returns the parser to the start of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> phase_q == usip_pkg::PH_START && !err_q && !saw_digit_q)
		else $error("state not cleared after result");

	// The drain phase always carries the error flag
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == usip_pkg::PH_DRAIN |-> err_q)
		else $error("drain phase without error");

	// Input stalls only for a waiting NUL behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && is_nul_s1 && result_valid)
		else $error("input stalled without a blocked result");

endmodule

>>> tb/unsigned_integer_string_parser_top_tb.sv
// Testbench for the unsigned integer string parser: random strings, predicted results, idle and stall bursts.
module unsigned_integer_string_parser_top_tb;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 5;
	localparam int ITEM_TARGET   = 850;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;

	// Whitespace codes that the package does not name
	localparam logic [7:0] CH_VT = 8'd11;
	localparam logic [7:0] CH_FF = 8'd12;
	localparam logic [7:0] WS_CODES [6] = '{usip_pkg::CH_SPACE, usip_pkg::CH_TAB,
		usip_pkg::CH_LF, CH_VT, CH_FF, usip_pkg::CH_CR};

	typedef logic [7:0] text_t [$];

	// Track the parse of the current string and hold the numbers still owed by the block
	class number_tracker;
		logic [63:0]            acc;
		logic [2:0]             phase;
		logic [4:0]             base;
		bit                     saw_digit;
		bit                     bad_input;
		usip_pkg::usip_result_t owed_numbers [$];
		int                     mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			acc = '0;
			phase = usip_pkg::PH_START;
			base = usip_pkg::BASE_INFER;
			saw_digit = 1'b0;
			bad_input = 1'b0;
		endfunction

		function void flag_bad();
			bad_input = 1'b1;
			phase = usip_pkg::PH_DRAIN;
		endfunction

		function bit is_space(logic [7:0] c);
			return c == usip_pkg::CH_SPACE || c == usip_pkg::CH_TAB || c == usip_pkg::CH_LF ||
				c == CH_VT || c == CH_FF || c == usip_pkg::CH_CR;
		endfunction

		// Close the string: owe one number, then start over
		function void close_string();
			usip_pkg::usip_result_t r;
			r.parsed_value = (saw_digit && !bad_input) ? acc : '0;
			r.parse_status = (saw_digit && !bad_input) ? usip_pkg::STATUS_OK :
				usip_pkg::STATUS_ERR;
			owed_numbers.push_back(r);
			clear();
		endfunction

		// One character of the digit loop, never NUL
		function void take_digit(logic [7:0] c);
			logic [4:0] d;
			if (c >= usip_pkg::CH_ZERO && c <= usip_pkg::CH_NINE) begin
				d = 5'(c - usip_pkg::CH_ZERO);
			end else if (c >= usip_pkg::CH_LO_A && c <= usip_pkg::CH_LO_F) begin
				d = 5'(c - usip_pkg::CH_LO_A + 8'd10);
			end else if (c >= usip_pkg::CH_UP_A && c <= usip_pkg::CH_UP_F) begin
				d = 5'(c - usip_pkg::CH_UP_A + 8'd10);
			end else if (c == usip_pkg::CH_LF) begin
				phase = usip_pkg::PH_NEWL;
				return;
			end else begin
				flag_bad();
				return;
			end
			if (d >= base) begin
				flag_bad();
				return;
			end
			acc = acc * {59'd0, base} + {59'd0, d};
			saw_digit = 1'b1;
			phase = usip_pkg::PH_DIGITS;
		endfunction

		// Advance the parse by one accepted character
		function void accept_char(usip_pkg::usip_char_t it);
			logic [7:0] c;
			c = it.char_code;
			if (phase == usip_pkg::PH_START) begin
				base = it.number_base;
				phase = usip_pkg::PH_SPACE;
			end
			case (phase)
				usip_pkg::PH_SPACE: begin
					if (c == usip_pkg::CH_NUL) begin
						close_string();
					end else if (!is_space(c)) begin
						if (c == usip_pkg::CH_ZERO && (base == usip_pkg::BASE_INFER ||
							base == usip_pkg::BASE_HEX)) begin
							phase = usip_pkg::PH_ZERO;
						end else begin
							if (base == usip_pkg::BASE_INFER)
								base = usip_pkg::BASE_DEC;
							take_digit(c);
						end
					end
				end
				usip_pkg::PH_ZERO: begin
					if (c == usip_pkg::CH_LO_X || c == usip_pkg::CH_UP_X) begin
						base = usip_pkg::BASE_HEX;
						phase = usip_pkg::PH_DIGITS;
					end else if (base == usip_pkg::BASE_INFER) begin
						// lone zero is decimal zero; anything else goes octal
						if (c == usip_pkg::CH_NUL) begin
							acc = '0;
							saw_digit = 1'b1;
							close_string();
						end else begin
							base = usip_pkg::BASE_OCT;
							take_digit(c);
						end
					end else begin
						// hex without prefix: the zero counts as a digit
						acc = '0;
						saw_digit = 1'b1;
						phase = usip_pkg::PH_DIGITS;
						if (c == usip_pkg::CH_NUL)
							close_string();
						else
							take_digit(c);
					end
				end
				usip_pkg::PH_DIGITS: begin
					if (c == usip_pkg::CH_NUL)
						close_string();
					else
						take_digit(c);
				end
				usip_pkg::PH_NEWL: begin
					if (c == usip_pkg::CH_NUL)
						close_string();
					else
						flag_bad();
				end
				default: begin
					if (c == usip_pkg::CH_NUL) begin
						bad_input = 1'b1;
						close_string();
					end else begin
						flag_bad();
					end
				end
			endcase
		endfunction

		// Compare one accepted result with the oldest owed number
		function void check_number(usip_pkg::usip_result_t got);
			usip_pkg::usip_result_t want;
			if (owed_numbers.size() == 0) begin
				$display("%0t: unexpected result: value %h status %0b", $time,
					got.parsed_value, got.parse_status);
				mismatches++;
				return;
			end
			want = owed_numbers.pop_front();
			if (got.parsed_value !== want.parsed_value) begin
				$display("%0t: parsed_value mismatch: expected %h actual %h", $time,
					want.parsed_value, got.parsed_value);
				mismatches++;
			end
			if (got.parse_status !== want.parse_status) begin
				$display("%0t: parse_status mismatch: expected %0b actual %0b", $time,
					want.parse_status, got.parse_status);
				mismatches++;
			end
		endfunction

		function int owed();
			return owed_numbers.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   char_valid = 1'b0;
	logic                   char_stall;
	usip_pkg::usip_char_t   char_item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	usip_pkg::usip_result_t result_item;

	bit            calm = 1'b0;
	bit            long_hold = 1'b0;
	int            send_quiet = 0;
	int            items_sent = 0;
	int            cycle_count = 0;
	number_tracker tracker = new();

	unsigned_integer_string_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_item    (char_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always #HALF_PERIOD clk = ~clk;

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sample both handshakes mid-cycle, where every signal is settled
	always @(negedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				tracker.accept_char(char_item);
			if (result_valid && !result_stall)
				tracker.check_number(result_item);
		end
	end

	// Receiver: random stall bursts, quiet stretches, one long hold on request
	initial begin : result_side
		int quiet_left;
		quiet_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				result_stall <= 1'b0;
			end else if (!calm && quiet_left == 0 && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				result_stall <= 1'b0;
			end else if (quiet_left > 0) begin
				quiet_left--;
			end else if ($urandom_range(0, 49) == 0) begin
				quiet_left = $urandom_range(20, 80);
			end
		end
	end

	// Offer one item and hold it until taken; returns at the accepting edge
	task automatic send_char(input logic [7:0] c, input logic [4:0] b);
		usip_pkg::usip_char_t it;
		it.char_code = c;
		it.number_base = b;
		char_valid <= 1'b1;
		char_item <= it;
		@(negedge clk);
		while (char_stall) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic idle_chars(input int n);
		char_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Send a string; the base rides on every item but only the first one counts
	task automatic send_string(input text_t text, input logic [4:0] b);
		foreach (text[i]) begin
			if (!calm) begin
				if (send_quiet > 0)
					send_quiet--;
				else if ($urandom_range(0, 7) == 0)
					idle_chars($urandom_range(1, 6));
				else if ($urandom_range(0, 49) == 0)
					send_quiet = $urandom_range(20, 80);
			end
			send_char(text[i], (i == 0) ? b : 5'($urandom_range(0, 31)));
		end
	endtask

	task automatic wait_for_results();
		while (tracker.owed() != 0) @(posedge clk);
	endtask

	// Mostly well-formed numbers with random content; some broken, some noise
	function automatic void make_string(output text_t text, output logic [4:0] b);
		int  kind;
		int  n;
		int  eb;
		int  d;
		bit  infer_dec;
		text = {};
		case ($urandom_range(0, 5))
			0, 4: b = usip_pkg::BASE_INFER;
			1: b = usip_pkg::BASE_OCT;
			2: b = usip_pkg::BASE_DEC;
			3: b = usip_pkg::BASE_HEX;
			default: b = 5'($urandom_range(0, 31));
		endcase
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(1, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) text.push_back(WS_CODES[$urandom_range(0, 5)]);
			eb = (b == usip_pkg::BASE_INFER) ? 10 :
				((b > usip_pkg::BASE_HEX) ? 16 : int'(b));
			infer_dec = (b == usip_pkg::BASE_INFER);
			// optional prefix
			if ((b == usip_pkg::BASE_INFER || b == usip_pkg::BASE_HEX) &&
				$urandom_range(0, 2) == 0) begin
				text.push_back(usip_pkg::CH_ZERO);
				text.push_back($urandom_range(0, 1) ? usip_pkg::CH_LO_X : usip_pkg::CH_UP_X);
				eb = 16;
				infer_dec = 1'b0;
			end else if (b == usip_pkg::BASE_INFER && $urandom_range(0, 3) == 0) begin
				text.push_back(usip_pkg::CH_ZERO);
				eb = 8;
				infer_dec = 1'b0;
			end
			// long runs now and then to wrap the 64-bit value
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
			for (int k = 0; k < n; k++) begin
				d = (k == 0 && infer_dec) ? $urandom_range(1, 9) : $urandom_range(0, eb - 1);
				if (d < 10)
					text.push_back(8'(usip_pkg::CH_ZERO + d));
				else if ($urandom_range(0, 1))
					text.push_back(8'(usip_pkg::CH_LO_A + d - 10));
				else
					text.push_back(8'(usip_pkg::CH_UP_A + d - 10));
			end
			if ($urandom_range(0, 4) == 0)
				text.push_back(usip_pkg::CH_LF);
			if (kind >= 7)
				text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
		end
		text.push_back(usip_pkg::CH_NUL);
	endfunction

	initial begin : stimulus
		text_t      text;
		logic [4:0] b;
		bit         hold_done;
		bit         drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: empty, blanks only, zero forms, prefixes, newline, extremes
		text = {usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_INFER);
		text = {usip_pkg::CH_SPACE, usip_pkg::CH_TAB, usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_DEC);
		text = {usip_pkg::CH_ZERO, usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_INFER);
		text = {usip_pkg::CH_ZERO, usip_pkg::CH_LF, usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_INFER);
		text = {usip_pkg::CH_ZERO, usip_pkg::CH_LO_X, usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_INFER);
		text = {usip_pkg::CH_ZERO, usip_pkg::CH_UP_X, usip_pkg::CH_NINE, usip_pkg::CH_LO_F,
			usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_HEX);
		text = {usip_pkg::CH_NINE, usip_pkg::CH_LF, usip_pkg::CH_NUL};
		send_string(text, usip_pkg::BASE_DEC);
		text = {8'hFF, usip_pkg::CH_NUL};
		send_string(text, 5'h1F);
		text = {8'(usip_pkg::CH_ZERO + 1), usip_pkg::CH_ZERO, usip_pkg::CH_NUL};
		send_string(text, 5'd1);

		// Random strings with one long receiver hold and one full drain
		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent >= ITEM_TARGET / 3) begin
				long_hold = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= 2 * ITEM_TARGET / 3) begin
				idle_chars(1);
				wait_for_results();
				drain_done = 1'b1;
			end
			if (items_sent >= ITEM_TARGET * 85 / 100)
				calm = 1'b1;
			make_string(text, b);
			send_string(text, b);
		end

		idle_chars(1);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
rtl/usip_pkg.sv
rtl/unsigned_integer_string_parser_top.sv
tb/unsigned_integer_string_parser_top_tb.sv
